// File: src/spq_pkg.sv
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int VALUE_W     = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          count_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_POP    = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic   ins;
    logic   pop;
    value_t key;
  } cell_ctrl_t;

endpackage

// File: src/spq_cell.sv
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occupied,
  input  spq_pkg::value_t    left_value,
  input  logic               left_ge,
  input  spq_pkg::value_t    right_value,
  output spq_pkg::value_t    value,
  output logic               ge
);
  import spq_pkg::*;

  // empty slots count as larger than any key, so the ge pattern stays monotonic
  assign ge = !occupied || !(value < ctrl.key);

  always_ff @(posedge clk) begin
    if (ctrl.ins && ge) begin
      value <= left_ge ? left_value : ctrl.key;
    end else if (ctrl.pop) begin
      value <= right_value;
    end
  end

endmodule

// File: src/sorted_priority_queue.sv
// channel | dir | tdata              | tuser      | meaning
// s_*     | in  | [31:0] value       | [0] mode   | insert (mode 0) or pop (mode 1)
// m_*     | out | [31:0] popped_value| [1:0] status| one result per input transaction
//
// one transaction per cycle while s_tready is high: every cell compares its entry
// against the broadcast key and takes the key, its left neighbor or its right
// neighbor in that same cycle; the result register parts the two sides; s_tready
// is low only while a result waits and m_tready is low
// rst (synchronous, active high) empties the queue; entry contents are not cleared
module sorted_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] popped_value
  output logic [1:0]  m_tuser    // [1:0] status
);
  import spq_pkg::*;

  count_t     count;
  count_t     count_next;
  cell_ctrl_t ctrl;
  value_t     cell_value [QUEUE_DEPTH];
  logic       cell_ge    [QUEUE_DEPTH];
  logic       accept;
  logic       is_pop;
  logic       full;
  logic       empty;
  value_t     res_value_next;
  status_t    res_status_next;
  value_t     res_value;
  status_t    res_status;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_pop   = (mode_t'(s_tuser) == MODE_POP);
  assign full     = (count == count_t'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  // broadcast control for the row of cells
  always_comb begin
    ctrl.ins = accept && !is_pop && !full;
    ctrl.pop = accept && is_pop && !empty;
    ctrl.key = value_t'(s_tdata);
  end

  // cell i shifts right when an insert lands at or below it, left on a pop
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    value_t left_v;
    logic   left_g;
    value_t right_v;

    if (i == 0) begin : g_head
      assign left_v = '0;
      assign left_g = 1'b0;
    end else begin : g_body
      assign left_v = cell_value[i-1];
      assign left_g = cell_ge[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_v = cell_value[i];
    end else begin : g_mid
      assign right_v = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (count_t'(i) < count),
      .left_value  (left_v),
      .left_ge     (left_g),
      .right_value (right_v),
      .value       (cell_value[i]),
      .ge          (cell_ge[i])
    );
  end

  // result and occupancy for the current transaction
  always_comb begin
    count_next      = count;
    res_value_next  = '0;
    res_status_next = STATUS_OK;
    if (is_pop) begin
      if (empty) begin
        res_status_next = STATUS_EMPTY;
      end else begin
        res_value_next = cell_value[0];
        count_next     = count - count_t'(1);
      end
    end else begin
      if (full) begin
        res_status_next = STATUS_FULL;
      end else begin
        count_next = count + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_value  <= res_value_next;
      res_status <= res_status_next;
    end
  end

  assign m_tdata = res_value;
  assign m_tuser = res_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(QUEUE_DEPTH))
    else $error("occupancy above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_pop && !full) |=> (count == $past(count) + count_t'(1)))
    else $error("insert did not grow occupancy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != STATUS_OK) |-> (m_tdata == '0))
    else $error("failed transaction carries data");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STATUS_FULL) |-> full)
    else $error("full status while queue not full");

endmodule
